@@ hdl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg: shared types for the first-fit heap allocator
// Segment table entry, request/result payloads and status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

  typedef struct packed {
    logic [15:0] off;
    logic [16:0] size;
    logic        free;
  } seg_t;

  typedef struct packed {
    logic        func;
    logic [15:0] req_size;
    logic [15:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [2:0]  status;
    logic [16:0] bytes_in_use;
  } rsp_t;

  localparam logic       FUNC_ALLOC = 1'b0;
  localparam logic       FUNC_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  localparam logic [12:0] MIN_SPLIT_RESET = 13'd16;
  localparam logic [6:0]  HDR_RESET       = 7'd20;

endpackage

@@ hdl/ffha_seg_ram.sv @@
// ----------------------------------------------------------------------------
// ffha_seg_ram: segment table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_seg_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ffha_pkg::seg_t  wdata,
  input  logic [AW-1:0]   raddr,
  output ffha_pkg::seg_t  rdata
);

  ffha_pkg::seg_t mem [DEPTH];
  ffha_pkg::seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit segment allocator with split and merge
// Allocate: a size-rounding step (S_DIV), then a read and a check (S_RD, S_CHK)
// per segment scanned. A split moves table entries up (S_MV_RD, S_MV_WR), then
// writes two entries (S_WR1, S_WR0). Free: a read and a check per segment, merge
// checks on the next and previous entries, one table write, then after a merge
// entries moved down; S_DONE posts the result. One request in flight at a time.
// Reset: synchronous; S_INIT writes the initial free segment to the table.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 65536,
  parameter int MAX_SEGMENTS = 64,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffha_pkg::req_t       in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffha_pkg::rsp_t       out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  // ceil(2^23 / ALIGN_BYTES): exact quotient for any 17-bit dividend
  localparam int RECIP = ((1 << 23) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam logic [23:0]   RECIP_C   = 24'(RECIP);
  localparam logic [16:0]   ALIGN_17  = 17'(ALIGN_BYTES);
  localparam logic [16:0]   ALIGN_M1  = 17'(ALIGN_BYTES - 1);
  localparam logic [16:0]   INIT_SIZE = 17'(HEAP_BYTES - int'(ffha_pkg::HDR_RESET));
  localparam logic [CW-1:0] MAX_C     = CW'(MAX_SEGMENTS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_RD, S_CHK, S_NRD, S_NCHK, S_PCHK,
    S_MV_RD, S_MV_WR, S_WR1, S_WR0, S_DONE
  } state_t;

  state_t          state_r;
  logic [12:0]     min_r;
  logic [6:0]      hdr_r;
  logic            func_r;
  logic [15:0]     req_r;
  logic [15:0]     faddr_r;
  logic [16:0]     q_r;
  logic [16:0]     need_r;
  logic [CW-1:0]   count_r;
  logic [16:0]     used_r;
  logic [IW-1:0]   ra_r;
  logic [IW-1:0]   dst_r;
  logic [IW-1:0]   i_r;
  logic [1:0]      nm_r;
  logic            up_r;
  ffha_pkg::seg_t  cur_r;
  ffha_pkg::seg_t  prev_r;
  ffha_pkg::seg_t  nw_r;
  logic [15:0]     addr_r;
  logic [2:0]      st_r;
  logic            out_valid_r;
  ffha_pkg::rsp_t  out_r;

  logic            seg_we;
  logic [IW-1:0]   seg_waddr;
  ffha_pkg::seg_t  seg_wdata;
  ffha_pkg::seg_t  rdata;

  logic            in_acc;
  logic            cfg_wr;
  logic [40:0]     q_prod;
  logic [17:0]     hdr18;
  logic [17:0]     split_lim;
  logic [18:0]     used_sum;
  logic [17:0]     used_v;
  logic [CW-1:0]   ra_c;
  logic [CW-1:0]   i_c;
  logic [CW-1:0]   dst_c;
  logic [16:0]     gsize;

  function automatic logic adj(ffha_pkg::seg_t a, logic [15:0] boff, logic [6:0] h);
    logic [17:0] s;
    s = 18'(a.off) + 18'(h) + 18'(a.size);
    return (s[17:16] == 2'b00) && (s[15:0] == boff);
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {25'd0, hdr_r} : {19'd0, min_r};

  assign q_prod    = 41'(17'(req_r) + ALIGN_M1) * 41'(RECIP_C);
  assign hdr18     = 18'(hdr_r);
  assign split_lim = 18'(need_r) + hdr18 + 18'(min_r);
  assign ra_c      = CW'(ra_r);
  assign i_c       = CW'(i_r);
  assign dst_c     = CW'(dst_r);

  // granted size: need on split, whole segment otherwise
  assign gsize = ((18'(rdata.size) >= split_lim) && (count_r < MAX_C)) ? need_r : rdata.size;
  assign used_v = (func_r == ffha_pkg::FUNC_ALLOC) ? (18'(gsize) + hdr18)
                                                   : (18'(rdata.size) + hdr18);
  assign used_sum = 19'(used_r) + 19'(used_v);

  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = dst_r;
    seg_wdata = rdata;
    case (state_r)
      S_INIT: begin
        seg_we    = 1'b1;
        seg_waddr = '0;
        seg_wdata = '{off: 16'd0, size: INIT_SIZE, free: 1'b1};
      end
      S_WR0: begin
        seg_we    = 1'b1;
        seg_waddr = i_r;
        seg_wdata = cur_r;
      end
      S_WR1: begin
        seg_we    = 1'b1;
        seg_waddr = IW'(i_c + CW'(1));
        seg_wdata = nw_r;
      end
      S_MV_WR: begin
        seg_we    = 1'b1;
        seg_waddr = dst_r;
        seg_wdata = rdata;
      end
      default: begin
        seg_we = 1'b0;
      end
    endcase
  end

  ffha_seg_ram #(.DEPTH(MAX_SEGMENTS), .AW(IW)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (ra_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      min_r       <= ffha_pkg::MIN_SPLIT_RESET;
      hdr_r       <= ffha_pkg::HDR_RESET;
      count_r     <= CW'(1);
      used_r      <= '0;
      out_valid_r <= 1'b0;
      ra_r        <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2]) hdr_r <= cfg_pwdata[6:0];
        else              min_r <= cfg_pwdata[12:0];
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_INIT: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            func_r    <= in_data.func;
            req_r     <= in_data.req_size;
            faddr_r   <= in_data.free_addr;
            addr_r    <= '0;
            st_r      <= ffha_pkg::ST_OK;
            nm_r      <= '0;
            ra_r      <= '0;
            if (in_data.func == ffha_pkg::FUNC_ALLOC) begin
              if (in_data.req_size == 16'd0) begin
                st_r    <= ffha_pkg::ST_ZERO;
                state_r <= S_DONE;
              end else begin
                state_r <= S_DIV;
              end
            end else if (in_data.free_addr == 16'd0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_DIV: begin
          q_r     <= q_prod[39:23];
          state_r <= S_RD;
        end
        S_RD: begin
          if (func_r == ffha_pkg::FUNC_ALLOC && ra_r == '0) begin
            need_r <= q_r * ALIGN_17;
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (func_r == ffha_pkg::FUNC_ALLOC) begin
            if (rdata.free && rdata.size >= need_r) begin
              i_r    <= ra_r;
              cur_r  <= '{off: rdata.off, size: gsize, free: 1'b0};
              addr_r <= rdata.off + 16'(hdr_r);
              used_r <= (used_sum > 19'h1FFFF) ? 17'h1FFFF : used_sum[16:0];
              nw_r   <= '{off:  16'(18'(rdata.off) + hdr18 + 18'(need_r)),
                          size: 17'(18'(rdata.size) - 18'(need_r) - hdr18),
                          free: 1'b1};
              if ((18'(rdata.size) >= split_lim) && (count_r < MAX_C)) begin
                count_r <= count_r + CW'(1);
                up_r    <= 1'b1;
                if (count_r >= ra_c + CW'(2)) begin
                  dst_r   <= IW'(count_r);
                  ra_r    <= IW'(count_r - CW'(1));
                  state_r <= S_MV_RD;
                end else begin
                  state_r <= S_WR1;
                end
              end else begin
                state_r <= S_WR0;
              end
            end else if (ra_c + CW'(1) < count_r) begin
              ra_r    <= ra_r + IW'(1);
              state_r <= S_RD;
            end else begin
              st_r    <= ffha_pkg::ST_NOFIT;
              state_r <= S_DONE;
            end
          end else begin
            if ((rdata.off + 16'(hdr_r)) == faddr_r) begin
              if (rdata.free) begin
                st_r    <= ffha_pkg::ST_DOUBLE;
                state_r <= S_DONE;
              end else begin
                i_r    <= ra_r;
                cur_r  <= '{off: rdata.off, size: rdata.size, free: 1'b1};
                used_r <= (used_v > 18'(used_r)) ? 17'd0 : 17'(18'(used_r) - used_v);
                up_r   <= 1'b0;
                if (ra_c + CW'(1) < count_r) begin
                  ra_r    <= ra_r + IW'(1);
                  state_r <= S_NRD;
                end else begin
                  state_r <= S_PCHK;
                end
              end
            end else begin
              prev_r <= rdata;
              if (ra_c + CW'(1) < count_r) begin
                ra_r    <= ra_r + IW'(1);
                state_r <= S_RD;
              end else begin
                st_r    <= ffha_pkg::ST_BADADDR;
                state_r <= S_DONE;
              end
            end
          end
        end
        S_NRD: begin
          state_r <= S_NCHK;
        end
        S_NCHK: begin
          if (rdata.free && adj(cur_r, rdata.off, hdr_r)) begin
            cur_r.size <= 17'(18'(cur_r.size) + hdr18 + 18'(rdata.size));
            nm_r       <= 2'd1;
          end
          state_r <= S_PCHK;
        end
        S_PCHK: begin
          if (i_r != '0 && prev_r.free && adj(prev_r, cur_r.off, hdr_r)) begin
            cur_r   <= '{off:  prev_r.off,
                         size: 17'(18'(prev_r.size) + hdr18 + 18'(cur_r.size)),
                         free: 1'b1};
            i_r     <= i_r - IW'(1);
            nm_r    <= nm_r + 2'd1;
            count_r <= count_r - CW'(nm_r) - CW'(1);
          end else begin
            count_r <= count_r - CW'(nm_r);
          end
          state_r <= S_WR0;
        end
        S_MV_RD: begin
          state_r <= S_MV_WR;
        end
        S_MV_WR: begin
          if (up_r) begin
            if (dst_c > i_c + CW'(2)) begin
              dst_r   <= dst_r - IW'(1);
              ra_r    <= ra_r - IW'(1);
              state_r <= S_MV_RD;
            end else begin
              state_r <= S_WR1;
            end
          end else begin
            if (dst_c + CW'(1) < count_r) begin
              dst_r   <= dst_r + IW'(1);
              ra_r    <= ra_r + IW'(1);
              state_r <= S_MV_RD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_WR1: begin
          state_r <= S_WR0;
        end
        S_WR0: begin
          if (func_r == ffha_pkg::FUNC_FREE && nm_r != 2'd0 && i_c + CW'(1) < count_r) begin
            dst_r   <= i_r + IW'(1);
            ra_r    <= IW'(i_c + CW'(1) + CW'(nm_r));
            state_r <= S_MV_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_r       <= '{result_addr: addr_r, status: st_r, bytes_in_use: used_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= MAX_C))
    else $error("segment count out of range");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    seg_we |-> (state_r == S_INIT || state_r == S_WR0 || state_r == S_WR1 ||
                state_r == S_MV_WR))
    else $error("table write outside a write state");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("request accepted without leaving idle");

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("result not posted on completion");
`endif

endmodule
